>>> design/hsvrgb_pkg.sv
// Shared constants, sector codes and the divide-by-255 helper for the colour converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam int unsigned HueWidth    = 16;
   localparam int unsigned ChanWidth   = 8;
   localparam int unsigned HWidth      = 9;
   localparam int unsigned NumStages   = 7;

   localparam logic [15:0] FullCircle  = 16'd360;
   localparam logic [8:0]  SectorSpan  = 9'd60;
   localparam logic [7:0]  UnitScale   = 8'd255;

   // Reciprocal of 360 scaled by 2^24, rounded down; the estimate it gives is
   // the true quotient or one below it.
   localparam int unsigned RecipShift  = 24;
   localparam logic [15:0] RecipCircle = 16'(((1 << RecipShift) / 360));

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   // Floor division by 255 for products of two bytes, without a divider.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

>>> design/hsv_to_rgb_converter_unit.sv
// Top level of the pipelined HSV to RGB colour converter.
`timescale 1ns / 1ps

// HSV to RGB converter, one word per clock while the receiver does not stall.
//
// The request channel carries a hue in degrees (any 16-bit value, reduced
// modulo 360 inside), a saturation and a value. The response channel returns
// the red, green and blue intensities of that colour. Both channels use a
// valid and stall pair: a word moves on a rising edge where valid is high and
// stall is low.
//
// The datapath is a seven-stage pipeline: hue reduction by reciprocal
// multiplication, correction, sector and fraction, the saturation products,
// the complement terms, the value products and the sector selection into
// the output register. One word per cycle gets through while the receiver
// does not stall, as every stage can take a new word in the same edge as
// its own word moves on.
//
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves on, so bubbles are squeezed out while the receiver
// stalls and the request side keeps accepting until the pipeline is full.
// A stalled response holds its value. Reset empties the pipeline; the data
// registers themselves are not reset.
module hsv_to_rgb_converter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hsvrgb_pkg::HueWidth-1:0]  req_hue_degrees,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] req_saturation,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] req_brightness_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hsvrgb_pkg::ChanWidth-1:0] rsp_red_out,
   output logic [hsvrgb_pkg::ChanWidth-1:0] rsp_green_out,
   output logic [hsvrgb_pkg::ChanWidth-1:0] rsp_blue_out
);
   import hsvrgb_pkg::*;

   // Valid bit of every stage and the load enable that each stage derives
   // from the one after it.
   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] load;

   // Stage 0: quotient estimate of the hue by 360.
   logic [7:0]  quot_ff,  quot_in;
   logic [15:0] hue0_ff;
   logic [7:0]  sat0_ff,  val0_ff;
   logic [31:0] recip_prod;

   // Stage 1: reduced hue.
   logic [HWidth-1:0] h_ff, h_in;
   logic [7:0]  sat1_ff,  val1_ff;
   logic [15:0] quot_times;
   logic [15:0] hue_rem;

   // Stage 2: sector, fraction and the numerator of p.
   sector_type  sector2_ff, sector2_in;
   logic [7:0]  frac_ff,    frac_in;
   logic [15:0] pnum_ff,    pnum_in;
   logic [7:0]  sat2_ff,    val2_ff;
   logic [HWidth-1:0] sector_base;
   logic [5:0]  sector_pos;
   logic [9:0]  frac_scaled;

   // Stage 3: saturation products and p.
   logic [15:0] sf_ff, sf_in;
   logic [15:0] sg_ff, sg_in;
   logic [7:0]  p3_ff, p3_in;
   sector_type  sector3_ff;
   logic [7:0]  val3_ff;

   // Stage 4: complement terms for q and t.
   logic [7:0]  qa_ff, qa_in;
   logic [7:0]  ta_ff, ta_in;
   logic [7:0]  p4_ff;
   sector_type  sector4_ff;
   logic [7:0]  val4_ff;

   // Stage 5: value products for q and t.
   logic [15:0] qn_ff, qn_in;
   logic [15:0] tn_ff, tn_in;
   logic [7:0]  p5_ff;
   sector_type  sector5_ff;
   logic [7:0]  val5_ff;

   // Stage 6: output register.
   logic [7:0]  red_ff,   red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff,  blue_in;
   logic [7:0]  q_term,   t_term;

   // A stage loads when it is empty or its word is leaving.
   always_comb begin
      load[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage 0 logic.
   assign recip_prod = {16'd0, req_hue_degrees} * {16'd0, RecipCircle};
   assign quot_in    = recip_prod[RecipShift+7:RecipShift];

   // Stage 1 logic: the remainder is below twice 360, so one correction does.
   always_comb begin
      quot_times = 16'({8'd0, quot_ff} * FullCircle);
      hue_rem    = hue0_ff - quot_times;
      if (hue_rem[9:0] >= FullCircle[9:0]) begin
         h_in = HWidth'(hue_rem[9:0] - FullCircle[9:0]);
      end else begin
         h_in = HWidth'(hue_rem[9:0]);
      end
   end

   // Stage 2 logic: the fraction is pos * 255 / 60, which is pos * 17 / 4.
   always_comb begin
      if (h_ff < HWidth'(SectorSpan)) begin
         sector2_in  = SECTOR_RED_YELLOW;
      end else if (h_ff < HWidth'(2 * SectorSpan)) begin
         sector2_in  = SECTOR_YELLOW_GREEN;
      end else if (h_ff < HWidth'(3 * SectorSpan)) begin
         sector2_in  = SECTOR_GREEN_CYAN;
      end else if (h_ff < HWidth'(4 * SectorSpan)) begin
         sector2_in  = SECTOR_CYAN_BLUE;
      end else if (h_ff < HWidth'(5 * SectorSpan)) begin
         sector2_in  = SECTOR_BLUE_MAGENTA;
      end else begin
         sector2_in  = SECTOR_MAGENTA_RED;
      end
      sector_base = HWidth'({6'd0, sector2_in} * SectorSpan);
      sector_pos  = 6'(h_ff - sector_base);
      frac_scaled = {4'd0, sector_pos} * 10'd17;
      frac_in     = frac_scaled[9:2];
      pnum_in     = {8'd0, val1_ff} * {8'd0, UnitScale - sat1_ff};
   end

   // Stage 3 logic.
   assign sf_in = {8'd0, sat2_ff} * {8'd0, frac_ff};
   assign sg_in = {8'd0, sat2_ff} * {8'd0, UnitScale - frac_ff};
   assign p3_in = div255(pnum_ff);

   // Stage 4 logic.
   assign qa_in = UnitScale - div255(sf_ff);
   assign ta_in = UnitScale - div255(sg_ff);

   // Stage 5 logic.
   assign qn_in = {8'd0, val4_ff} * {8'd0, qa_ff};
   assign tn_in = {8'd0, val4_ff} * {8'd0, ta_ff};

   // Stage 6 logic: the sector decides which term drives each channel.
   always_comb begin
      q_term = div255(qn_ff);
      t_term = div255(tn_ff);
      case (sector5_ff)
         SECTOR_RED_YELLOW: begin
            red_in = val5_ff; green_in = t_term;  blue_in = p5_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = q_term;  green_in = val5_ff; blue_in = p5_ff;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = p5_ff;   green_in = val5_ff; blue_in = t_term;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = p5_ff;   green_in = q_term;  blue_in = val5_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = t_term;  green_in = p5_ff;   blue_in = val5_ff;
         end
         default: begin
            red_in = val5_ff; green_in = p5_ff;   blue_in = q_term;
         end
      endcase
   end

   // Data registers move with their stage's load enable.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         quot_ff <= quot_in;
         hue0_ff <= req_hue_degrees;
         sat0_ff <= req_saturation;
         val0_ff <= req_brightness_value;
      end
      if (load[1]) begin
         h_ff    <= h_in;
         sat1_ff <= sat0_ff;
         val1_ff <= val0_ff;
      end
      if (load[2]) begin
         sector2_ff <= sector2_in;
         frac_ff    <= frac_in;
         pnum_ff    <= pnum_in;
         sat2_ff    <= sat1_ff;
         val2_ff    <= val1_ff;
      end
      if (load[3]) begin
         sf_ff      <= sf_in;
         sg_ff      <= sg_in;
         p3_ff      <= p3_in;
         sector3_ff <= sector2_ff;
         val3_ff    <= val2_ff;
      end
      if (load[4]) begin
         qa_ff      <= qa_in;
         ta_ff      <= ta_in;
         p4_ff      <= p3_ff;
         sector4_ff <= sector3_ff;
         val4_ff    <= val3_ff;
      end
      if (load[5]) begin
         qn_ff      <= qn_in;
         tn_ff      <= tn_in;
         p5_ff      <= p4_ff;
         sector5_ff <= sector4_ff;
         val5_ff    <= val4_ff;
      end
      if (load[6]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign req_stall     = !load[0];
   assign rsp_valid     = valid_ff[NumStages-1];
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   // An accepted request word always occupies the first stage afterwards.
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted word did not enter the pipeline");

   // The reciprocal estimate and its correction leave a hue below 360.
   a_hue_reduced : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (h_ff < FullCircle[HWidth-1:0]))
      else $error("reduced hue out of range");

   // The scaled fraction never passes 250.
   a_frac_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (frac_ff <= 8'd250))
      else $error("sector fraction out of range");

   // A full pipeline with a stalled receiver pushes back on the request side.
   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && rsp_stall) |-> req_stall)
      else $error("full pipeline accepted a word while stalled");

   // A word held at the output while stalled is still valid, with red and blue unchanged, in the next cycle.
   a_output_kept : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(red_ff) && $stable(blue_ff)))
      else $error("stalled response word was lost");

endmodule

>>> test/hsv_rgb_checker.sv
// Checker for the colour converter: predicts each response word and compares it.
`timescale 1ns / 1ps

module hsv_rgb_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [hsvrgb_pkg::HueWidth-1:0]  req_hue_degrees,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] req_saturation,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] req_brightness_value,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] rsp_red_out,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] rsp_green_out,
   input  logic [hsvrgb_pkg::ChanWidth-1:0] rsp_blue_out,
   output int unsigned                      mismatches,
   output int unsigned                      colours_in_flight
);
   import hsvrgb_pkg::*;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_word_type;

   rgb_word_type pending_colours[$];

   // Integer HSV to RGB with floor divisions throughout.
   function automatic rgb_word_type hsv_colour(input logic [HueWidth-1:0] hue,
                                               input logic [ChanWidth-1:0] sat,
                                               input logic [ChanWidth-1:0] val);
      int unsigned  h, s, v, span, scale, frac, p, q, t;
      sector_type   sector;
      rgb_word_type c;
      scale  = UnitScale;
      span   = SectorSpan;
      h      = hue % int'(FullCircle);
      s      = sat;
      v      = val;
      sector = sector_type'(h / span);
      frac   = ((h % span) * scale) / span;
      p      = (v * (scale - s)) / scale;
      q      = (v * (scale - (s * frac) / scale)) / scale;
      t      = (v * (scale - (s * (scale - frac)) / scale)) / scale;
      case (sector)
         SECTOR_RED_YELLOW: begin
            c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0];
         end
         SECTOR_YELLOW_GREEN: begin
            c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0];
         end
         SECTOR_GREEN_CYAN: begin
            c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0];
         end
         SECTOR_CYAN_BLUE: begin
            c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0];
         end
         SECTOR_BLUE_MAGENTA: begin
            c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0];
         end
         default: begin
            c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0];
         end
      endcase
      return c;
   endfunction

   always @(posedge clock) begin
      rgb_word_type want;
      int unsigned  errs;
      errs = mismatches;
      if (!reset) begin
         // Responses are taken first so that a stray word is never matched
         // against a request accepted on the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (pending_colours.size() == 0) begin
               $error("response word with no request outstanding: r=%0d g=%0d b=%0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               errs++;
            end else begin
               want = pending_colours.pop_front();
               if (rsp_red_out !== want.red) begin
                  $error("red_out: expected %0d, got %0d", want.red, rsp_red_out);
                  errs++;
               end
               if (rsp_green_out !== want.green) begin
                  $error("green_out: expected %0d, got %0d", want.green, rsp_green_out);
                  errs++;
               end
               if (rsp_blue_out !== want.blue) begin
                  $error("blue_out: expected %0d, got %0d", want.blue, rsp_blue_out);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_colours.push_back(hsv_colour(req_hue_degrees, req_saturation,
                                                 req_brightness_value));
      end
      mismatches        <= errs;
      colours_in_flight <= pending_colours.size();
   end

   final begin
      if (pending_colours.size() != 0)
         $error("%0d response words never arrived", pending_colours.size());
   end

endmodule

>>> test/tb.sv
// Top of the colour converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The converter is driven with directed corner words followed by random
// ones, while the checker beside it predicts every response and compares the
// red, green and blue fields. The run is split into three idling phases:
// first the sender idles lightly while the receiver stalls heavily, then the
// other way round, and finally both sides run flat out. Between the first and
// second phase the sender holds off until the pipeline has drained.
module tb;
   import hsvrgb_pkg::*;

   localparam int unsigned CycleLimit  = 200_000;
   localparam int unsigned DrainCycles = 16;
   localparam int unsigned PhaseWords  = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [HueWidth-1:0]  req_hue_degrees = '0;
   logic [ChanWidth-1:0] req_saturation = '0;
   logic [ChanWidth-1:0] req_brightness_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ChanWidth-1:0] rsp_red_out;
   logic [ChanWidth-1:0] rsp_green_out;
   logic [ChanWidth-1:0] rsp_blue_out;

   int unsigned mismatches;
   int unsigned colours_in_flight;
   int unsigned cycle_count = 0;

   // Idling rates in percent for each side; changed between phases.
   int unsigned sender_idle_pct   = 13;
   int unsigned receiver_idle_pct = 52;

   initial begin
      forever #4 clock = ~clock;
   end

   hsv_to_rgb_converter_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_hue_degrees     (req_hue_degrees),
      .req_saturation      (req_saturation),
      .req_brightness_value(req_brightness_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out)
   );

   hsv_rgb_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_hue_degrees     (req_hue_degrees),
      .req_saturation      (req_saturation),
      .req_brightness_value(req_brightness_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out),
      .mismatches          (mismatches),
      .colours_in_flight   (colours_in_flight)
   );

   // The receiver stalls at random, at whatever rate the current phase sets.
   // It is held open during reset so that nothing is left hanging.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Watchdog: a correct run finishes far inside this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offers one word and returns once it has been accepted. Any idle cycles
   // come before the word, so a gap can fall anywhere in the pipeline's work.
   // Valid stays high from one word to the next when no gap is drawn.
   task automatic offer_colour(input logic [HueWidth-1:0]  hue,
                               input logic [ChanWidth-1:0] sat,
                               input logic [ChanWidth-1:0] val);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_hue_degrees      <= hue;
      req_saturation       <= sat;
      req_brightness_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until the checker has nothing outstanding. The
   // first edge lets the checker's count catch up with the last acceptance.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (colours_in_flight != 0);
   endtask

   // Mostly hues within the first two turns of the circle, so that every
   // sector is hit often, with the full 16-bit range mixed in. Saturation and
   // value lean now and then towards their extremes.
   task automatic offer_random_colours(input int unsigned count);
      logic [HueWidth-1:0]  hue;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0:       hue = HueWidth'($urandom_range(0, 65535));
            1:       hue = HueWidth'($urandom_range(65535 - 400, 65535));
            default: hue = HueWidth'($urandom_range(0, 719));
         endcase
         case ($urandom_range(0, 9))
            0:       sat = '0;
            1:       sat = '1;
            default: sat = ChanWidth'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0:       val = '0;
            1:       val = '1;
            default: val = ChanWidth'($urandom_range(0, 255));
         endcase
         offer_colour(hue, sat, val);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: both edges of each sector, a hue of exactly one
      // full turn, the largest hue word, grey at zero saturation, and black.
      offer_colour(16'd0,     8'd255, 8'd255);
      offer_colour(16'd59,    8'd255, 8'd255);
      offer_colour(16'd60,    8'd255, 8'd255);
      offer_colour(16'd119,   8'd255, 8'd255);
      offer_colour(16'd120,   8'd200, 8'd255);
      offer_colour(16'd179,   8'd255, 8'd128);
      offer_colour(16'd180,   8'd255, 8'd255);
      offer_colour(16'd239,   8'd1,   8'd255);
      offer_colour(16'd240,   8'd255, 8'd255);
      offer_colour(16'd299,   8'd128, 8'd200);
      offer_colour(16'd300,   8'd255, 8'd255);
      offer_colour(16'd359,   8'd255, 8'd255);
      offer_colour(16'd360,   8'd255, 8'd255);
      offer_colour(16'd720,   8'd100, 8'd100);
      offer_colour(16'd65535, 8'd255, 8'd255);
      offer_colour(16'd65535, 8'd0,   8'd0);
      offer_colour(16'd30,    8'd0,   8'd173);
      offer_colour(16'd200,   8'd0,   8'd255);
      offer_colour(16'd90,    8'd255, 8'd0);
      offer_colour(16'd330,   8'd254, 8'd1);
      offer_colour(16'd150,   8'd1,   8'd254);

      // First phase: light sender gaps against a heavily stalling receiver,
      // which fills the pipeline and exercises back-pressure.
      offer_random_colours(PhaseWords);

      // Let everything drain before the sides swap roles.
      drain_pipeline();

      sender_idle_pct   = 52;
      receiver_idle_pct = 13;
      offer_random_colours(PhaseWords);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      offer_random_colours(PhaseWords);

      // Wait for the last responses, then keep watching for DrainCycles in case the
      // block produces anything it should not.
      drain_pipeline();
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
